// ===== rtl/bta_pkg.sv =====
// Shared constants, types and helpers for the boundary-tag heap allocator.
package bta_pkg;

  localparam int HEAP_BYTES = 64;
  localparam int ADDR_W     = $clog2(HEAP_BYTES);
  localparam int POS_W      = ADDR_W + 1;   // holds 0..HEAP_BYTES
  localparam int TAG_W      = 8;
  localparam int SIZE_W     = 6;
  localparam int TAG_OVH    = 2;            // header + footer bytes

  typedef logic [ADDR_W-1:0] addr_t;
  typedef logic [POS_W-1:0]  pos_t;
  typedef logic [TAG_W-1:0]  tag_t;
  typedef logic [SIZE_W-1:0] size_t;

  typedef enum logic [1:0] {
    FN_ALLOC = 2'd0,
    FN_FREE  = 2'd1,
    FN_LIST  = 2'd2,
    FN_NONE  = 2'd3
  } func_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_NOFIT   = 2'd1,
    ST_BADFREE = 2'd2
  } status_t;

  typedef enum logic [4:0] {
    S_IDLE,
    S_A_RD, S_A_CHK, S_A_FOOT, S_A_RHEAD, S_A_RFOOT,
    S_F_RD, S_F_CHK, S_F_NRD, S_F_NCHK, S_F_PRD, S_F_PCHK, S_F_HEAD, S_F_FOOT,
    S_L_RD, S_L_CHK,
    S_EMIT
  } state_t;

  // Boundary tag: total span in bytes shifted left once, bit 0 = allocated.
  function automatic tag_t bta_tag(input size_t payload, input logic alloc);
    pos_t span;
    span = pos_t'(payload) + pos_t'(TAG_OVH);
    return {span, alloc};
  endfunction

  // Store contents after reset: one free block spanning the whole store.
  function automatic tag_t bta_rst_tag(input addr_t a);
    if (a == addr_t'(0) || a == addr_t'(HEAP_BYTES - 1)) return tag_t'(HEAP_BYTES * 2);
    return tag_t'(0);
  endfunction

endpackage

// ===== rtl/bta_if.sv =====
// Request and response channel interfaces of the allocator.
interface bta_req_if;
  import bta_pkg::*;
  logic  valid;
  logic  ready;
  logic [1:0] func;
  size_t request_size;
  size_t free_index;
  modport source (output valid, func, request_size, free_index, input ready);
  modport sink   (input valid, func, request_size, free_index, output ready);
endinterface

interface bta_rsp_if;
  import bta_pkg::*;
  logic  valid;
  logic  ready;
  logic [1:0] status;
  size_t payload_index;
  size_t block_size;
  logic  allocated;
  logic  last;
  modport source (output valid, status, payload_index, block_size, allocated, last,
                  input ready);
  modport sink   (input valid, status, payload_index, block_size, allocated, last,
                  output ready);
endinterface

// ===== rtl/boundary_tag_heap_allocator_top.sv =====
// Boundary-tag heap allocator: top level with tag store and walk sequencer.
//
// The heap is a 64-byte store held in one synchronous RAM (one read, one write
// port, read data registered). Blocks are framed by a header and a footer tag,
// (payload + 2) << 1 with bit 0 marking an allocated block; only tags are kept,
// payload bytes carry no information a request can observe. One request is
// worked at a time. Allocate walks the chain first fit, one block at a time,
// then writes the header and footer tags, plus the remainder's two tags on a
// split. Free walks to the named header the same way, then reads the next
// header and the previous footer for merging and writes the new tags. List
// gives one beat per block, last set on the final one. Every other request
// answers with one beat except an unknown func, which gives none. The result
// sits in an output register, so the sequencer finishes while the sink
// stalls; ready drops during a request. The RAM read port sets the pace: each
// tag is read and checked before the next. Reset is immediate: a per-entry
// valid bit stands in for the initial store contents, no clear pass.
module boundary_tag_heap_allocator_top
  import bta_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  bta_req_if.sink    req,
  bta_rsp_if.source  rsp
);

  // ---- tag store ----
  tag_t              mem [HEAP_BYTES];
  logic [HEAP_BYTES-1:0] vld;
  tag_t              mem_q;
  logic              vld_q;
  addr_t             raddr_q;
  logic              re, we;
  addr_t             raddr, waddr;
  tag_t              wdata;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      mem_q   <= mem[raddr];
      raddr_q <= raddr;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld   <= '0;
      vld_q <= 1'b0;
    end else begin
      if (we) begin
        vld[waddr] <= 1'b1;
      end
      if (re) begin
        vld_q <= vld[raddr];
      end
    end
  end

  // Entry never written since reset reads as its reset tag.
  tag_t tag;
  assign tag = vld_q ? mem_q : bta_rst_tag(raddr_q);

  // ---- sequencer registers ----
  state_t state, state_next;
  pos_t   h;          // header position under the walk
  pos_t   s;          // span of the block being worked
  size_t  sz, idx, gsz;
  pos_t   size;       // payload of the block being freed/merged
  addr_t  foot;
  logic   split;

  status_t res_status;
  size_t   res_index, res_size;
  logic    res_alloc, res_last;

  logic    ovalid;
  status_t o_status;
  size_t   o_index, o_size;
  logic    o_alloc, o_last;

  // ---- decode of the tag just read ----
  pos_t  sp, rpos, room, len, h_end, idx_m1, nh, sz_w, nl_w;
  pos_t  a_foot_w, a_rhead_w, a_rfoot_w, f_foot_w, n_foot_w, h_dec, h_inc;
  logic  span_ok, fits, split_c, back_ok, out_free, accept, over;
  size_t gsz_c;

  assign sp       = tag[TAG_W-1:1];
  assign rpos     = pos_t'(raddr_q);
  assign room     = pos_t'(HEAP_BYTES) - rpos;
  assign span_ok  = (sp >= pos_t'(TAG_OVH)) && (sp <= room);
  assign len      = sp - pos_t'(TAG_OVH);
  assign sz_w     = pos_t'(sz);
  assign fits     = !tag[0] && (len >= sz_w);
  assign split_c  = len > (sz_w + pos_t'(TAG_OVH));
  assign gsz_c    = split_c ? sz : len[SIZE_W-1:0];
  assign h_end    = h + sp;
  assign idx_m1   = pos_t'(idx) - pos_t'(1);
  assign nh       = h + s;
  assign back_ok  = !tag[0] && (sp >= pos_t'(TAG_OVH)) && (sp <= h);
  assign over     = h >= pos_t'(HEAP_BYTES);

  assign a_foot_w  = h + pos_t'(gsz) + pos_t'(1);
  assign a_rhead_w = h + pos_t'(gsz) + pos_t'(TAG_OVH);
  assign a_rfoot_w = h + s - pos_t'(1);
  assign nl_w      = s - pos_t'(gsz) - pos_t'(2 * TAG_OVH);
  assign f_foot_w  = h_end - pos_t'(1);
  assign n_foot_w  = rpos + sp - pos_t'(1);
  assign h_dec     = h - pos_t'(1);
  assign h_inc     = h + pos_t'(1);

  assign out_free  = !ovalid || rsp.ready;
  assign req.ready = (state == S_IDLE);
  assign accept    = req.valid && req.ready;

  // ---- next state ----
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (req.valid) begin
          unique case (func_t'(req.func))
            FN_ALLOC: state_next = S_A_RD;
            FN_FREE:  state_next = (req.free_index == size_t'(0)) ? S_EMIT : S_F_RD;
            FN_LIST:  state_next = S_L_RD;
            default:  state_next = S_IDLE;
          endcase
        end
      end
      S_A_RD:    state_next = over ? S_EMIT : S_A_CHK;
      S_A_CHK: begin
        if (!span_ok)  state_next = S_EMIT;
        else if (fits) state_next = S_A_FOOT;
        else           state_next = S_A_RD;
      end
      S_A_FOOT:  state_next = split ? S_A_RHEAD : S_EMIT;
      S_A_RHEAD: state_next = S_A_RFOOT;
      S_A_RFOOT: state_next = S_EMIT;
      S_F_RD:    state_next = over ? S_EMIT : S_F_CHK;
      S_F_CHK: begin
        if (!span_ok)        state_next = S_EMIT;
        else if (h == idx_m1) state_next = tag[0] ? S_F_NRD : S_EMIT;
        else if (h > idx_m1)  state_next = S_EMIT;
        else                  state_next = S_F_RD;
      end
      S_F_NRD:   state_next = (nh >= pos_t'(HEAP_BYTES)) ? S_F_PRD : S_F_NCHK;
      S_F_NCHK:  state_next = S_F_PRD;
      S_F_PRD:   state_next = (h == pos_t'(0)) ? S_F_HEAD : S_F_PCHK;
      S_F_PCHK:  state_next = S_F_HEAD;
      S_F_HEAD:  state_next = S_F_FOOT;
      S_F_FOOT:  state_next = S_EMIT;
      S_L_RD:    state_next = over ? S_IDLE : S_L_CHK;
      S_L_CHK:   state_next = span_ok ? S_EMIT : S_IDLE;
      S_EMIT: begin
        if (out_free) state_next = res_last ? S_IDLE : S_L_RD;
      end
      default:   state_next = S_IDLE;
    endcase
  end

  // ---- RAM port control ----
  always_comb begin
    re    = 1'b0;
    raddr = h[ADDR_W-1:0];
    we    = 1'b0;
    waddr = h[ADDR_W-1:0];
    wdata = bta_tag(size[SIZE_W-1:0], 1'b0);
    unique case (state)
      S_A_RD, S_F_RD, S_L_RD: re = 1'b1;
      S_A_CHK: begin
        we    = span_ok && fits;
        wdata = bta_tag(gsz_c, 1'b1);
      end
      S_A_FOOT: begin
        we    = 1'b1;
        waddr = a_foot_w[ADDR_W-1:0];
        wdata = bta_tag(gsz, 1'b1);
      end
      S_A_RHEAD: begin
        we    = 1'b1;
        waddr = a_rhead_w[ADDR_W-1:0];
        wdata = bta_tag(nl_w[SIZE_W-1:0], 1'b0);
      end
      S_A_RFOOT: begin
        we    = 1'b1;
        waddr = a_rfoot_w[ADDR_W-1:0];
        wdata = bta_tag(nl_w[SIZE_W-1:0], 1'b0);
      end
      S_F_NRD: begin
        re    = 1'b1;
        raddr = nh[ADDR_W-1:0];
      end
      S_F_PRD: begin
        re    = 1'b1;
        raddr = h_dec[ADDR_W-1:0];
      end
      S_F_HEAD: we = 1'b1;
      S_F_FOOT: begin
        we    = 1'b1;
        waddr = foot;
      end
      default: ;
    endcase
  end

  // ---- control registers ----
  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      ovalid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == S_EMIT && out_free) begin
        ovalid <= 1'b1;
      end else if (rsp.ready) begin
        ovalid <= 1'b0;
      end
    end
  end

  // ---- walk datapath and result staging ----
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        if (accept) begin
          h          <= '0;
          sz         <= req.request_size;
          idx        <= req.free_index;
          res_status <= ST_BADFREE;   // default answer for a free that finds nothing
          res_index  <= '0;
          res_size   <= '0;
          res_alloc  <= 1'b0;
          res_last   <= 1'b1;
        end
      end
      S_A_RD: begin
        if (over) res_status <= ST_NOFIT;
      end
      S_A_CHK: begin
        if (!span_ok) begin
          res_status <= ST_NOFIT;
        end else if (fits) begin
          gsz   <= gsz_c;
          s     <= sp;
          split <= split_c;
        end else begin
          h <= h_end;
        end
      end
      S_A_FOOT, S_A_RFOOT: begin
        if (state == S_A_RFOOT || !split) begin
          res_status <= ST_OK;
          res_index  <= h_inc[SIZE_W-1:0];
          res_size   <= gsz;
          res_alloc  <= 1'b1;
        end
      end
      S_F_CHK: begin
        if (h == idx_m1) begin
          s    <= sp;
          size <= len;
          foot <= f_foot_w[ADDR_W-1:0];
        end else begin
          h <= h_end;
        end
      end
      S_F_NCHK: begin
        // forward merge with a free successor
        if (span_ok && !tag[0]) begin
          size <= size + sp;
          foot <= n_foot_w[ADDR_W-1:0];
        end
      end
      S_F_PCHK: begin
        // backward merge through the predecessor's footer
        if (back_ok) begin
          size <= size + sp;
          h    <= h - sp;
        end
      end
      S_F_FOOT: begin
        res_status <= ST_OK;
        res_index  <= h_inc[SIZE_W-1:0];
        res_size   <= size[SIZE_W-1:0];
        res_alloc  <= 1'b0;
      end
      S_L_CHK: begin
        res_status <= ST_OK;
        res_index  <= h_inc[SIZE_W-1:0];
        res_size   <= len[SIZE_W-1:0];
        res_alloc  <= tag[0];
        res_last   <= h_end >= pos_t'(HEAP_BYTES);
        h          <= h_end;
      end
      S_EMIT: begin
        if (out_free) begin
          o_status <= res_status;
          o_index  <= res_index;
          o_size   <= res_size;
          o_alloc  <= res_alloc;
          o_last   <= res_last;
        end
      end
      default: ;
    endcase
  end

  assign rsp.valid         = ovalid;
  assign rsp.status        = o_status;
  assign rsp.payload_index = o_index;
  assign rsp.block_size    = o_size;
  assign rsp.allocated     = o_alloc;
  assign rsp.last          = o_last;

endmodule

// ===== rtl/bta_checker.sv =====
// Port-level checks on the allocator, bound to its top level.
module bta_checker
  import bta_pkg::*;
(
  input logic       clk,
  input logic       rst,
  input logic       req_valid,
  input logic       req_ready,
  input logic [1:0] req_func,
  input logic       rsp_valid,
  input logic       rsp_ready,
  input logic [1:0] rsp_status,
  input size_t      rsp_payload_index,
  input size_t      rsp_block_size,
  input logic       rsp_allocated,
  input logic       rsp_last
);

  // a stalled response beat holds
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_payload_index) &&
    $stable(rsp_block_size) && $stable(rsp_status) && $stable(rsp_last))
    else $error("response beat changed while stalled");

  // one request in flight: a real request closes the request side
  a_one_req: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready && req_func != FN_NONE |=> !req_ready)
    else $error("request taken while another is in flight");

  // error beats are single and carry no block
  a_err_beat: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_status != ST_OK |-> rsp_last && rsp_payload_index == '0 &&
    rsp_block_size == '0 && !rsp_allocated)
    else $error("malformed error beat");

  // a reported block lies inside the store
  a_in_store: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_status == ST_OK |->
    rsp_payload_index != '0 &&
    (7'(rsp_payload_index) + 7'(rsp_block_size)) <= 7'(HEAP_BYTES - 1))
    else $error("reported block runs past the store");

endmodule

bind boundary_tag_heap_allocator_top bta_checker u_bta_checker (
  .clk              (clk),
  .rst              (rst),
  .req_valid        (req.valid),
  .req_ready        (req.ready),
  .req_func         (req.func),
  .rsp_valid        (rsp.valid),
  .rsp_ready        (rsp.ready),
  .rsp_status       (rsp.status),
  .rsp_payload_index(rsp.payload_index),
  .rsp_block_size   (rsp.block_size),
  .rsp_allocated    (rsp.allocated),
  .rsp_last         (rsp.last)
);
